// File: src/dswa_pkg.sv
// Package for the dual sensor window alarm: payload structs, command codes,
// register indexes, reset constants and the saturation helper.
// No dependencies.
`default_nettype none

package dswa_pkg;

   localparam int TEMP_W = 16;
   localparam int CNT_W  = 8;
   localparam int CSR_IDX_W = 3;
   // wide enough for a 32-bit limit plus a signed step
   localparam int WIDE_W = 34;

   typedef enum logic [2:0] {
      CMD_SAMPLE    = 3'd0,
      CMD_MUTE      = 3'd1,
      CMD_NEXT_SLOT = 3'd2,
      CMD_STEP_DOWN = 3'd3,
      CMD_STEP_UP   = 3'd4,
      CMD_SET_LIMIT = 3'd5,
      CMD_DEFAULTS  = 3'd6
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_LOW   = 3'd0,
      CSR_FIRST_HIGH  = 3'd1,
      CSR_SECOND_LOW  = 3'd2,
      CSR_SECOND_HIGH = 3'd3,
      CSR_CONFIRM     = 3'd4,
      CSR_STEP        = 3'd5
   } csr_type;

   localparam logic [3:0][TEMP_W-1:0] LIMIT_RST = {16'd1600, 16'd0, 16'd960, 16'd160};
   localparam logic [CNT_W-1:0] CONFIRM_RST = 8'd3;
   localparam logic [CNT_W-1:0] STEP_RST    = 8'd16;

   typedef struct packed {
      logic [2:0]               command;
      logic                     first_valid;
      logic signed [TEMP_W-1:0] first_temp;
      logic                     second_valid;
      logic signed [TEMP_W-1:0] second_temp;
      logic [1:0]               limit_slot;
      logic signed [TEMP_W-1:0] limit_value;
   } req_type;

   typedef struct packed {
      logic                     first_alarm;
      logic                     second_alarm;
      logic                     alarm_active;
      logic                     muted;
      logic                     alarm_drive;
      logic [1:0]               current_slot;
      logic signed [TEMP_W-1:0] slot_value;
      logic signed [TEMP_W-1:0] first_lowest;
      logic signed [TEMP_W-1:0] first_highest;
      logic signed [TEMP_W-1:0] second_lowest;
      logic signed [TEMP_W-1:0] second_highest;
   } rsp_type;

   // limit store controls for the item in flight
   typedef struct packed {
      logic       step_en;
      logic       step_down;
      logic       set_en;
      logic [1:0] set_slot;
      logic       load_en;
      logic [1:0] slot;
   } lim_ctrl_type;

   // clamp to the signed range of a bits-wide word
   function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v,
                                                         input int unsigned bits);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = $signed((WIDE_W'(1) << (bits - 1)) - WIDE_W'(1));
      lo = ~hi;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// File: src/dual_sensor_window_alarm_unit.sv
// Dual sensor window alarm, top level: config registers, input register,
// mute and slot state, result register. Depends on dswa_pkg, dswa_sensor, dswa_limits.
//
// Usage:
//   req_valid/req_stall/req_data carry one command item per transfer (a sensor
//   sample or a key event). rsp_valid/rsp_stall/rsp_data return exactly one
//   result per item, in order.
//   An item is captured in the input register, evaluated against the state
//   once the result register is free and lands there; rsp_valid then rises.
//   One item per cycle is sustained while the receiver does not stall; the
//   state update for each item is a single compare/add pass, done as the item
//   moves into the result register.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, then req_stall rises until the result drains.
//   The csr_ port writes the default limits, confirm count and step size; write
//   only while no item is in flight.
//   Reset (synchronous) loads the reset register values, the default limits,
//   clears extremes, confirm counters, mute and the slot pointer.
`default_nettype none

module dual_sensor_window_alarm_unit #(
   parameter int TEMP_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire dswa_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output dswa_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_write_en,
   input  wire logic [dswa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dswa_pkg::TEMP_W-1:0]        csr_wdata
);

   localparam int WW = dswa_pkg::WIDE_W;
   localparam int TW = dswa_pkg::TEMP_W;
   localparam int CW = dswa_pkg::CNT_W;

   logic [3:0][TW-1:0] def_ff;
   logic [CW-1:0]      confirm_ff;
   logic [CW-1:0]      step_ff;
   logic [CW-1:0]      need;

   logic               s1_valid_ff;
   dswa_pkg::req_type  s1_req_ff;
   logic               rsp_valid_ff;
   dswa_pkg::rsp_type  rsp_ff, rsp_in;
   logic               advance;

   logic               mute_ff, mute_in;
   logic [1:0]         slot_ff, slot_in;

   logic               is_sample;
   logic               a1_now, a2_now, a1_upd, a2_upd;
   logic               act_now, act_upd;
   logic signed [TW-1:0] lo1, hi1, lo2, hi2;
   logic signed [WW-1:0] slot_wide;

   dswa_pkg::lim_ctrl_type     lim_ctrl;
   logic [3:0][TEMP_BITS-1:0]  lim_now, lim_upd;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         def_ff     <= dswa_pkg::LIMIT_RST;
         confirm_ff <= dswa_pkg::CONFIRM_RST;
         step_ff    <= dswa_pkg::STEP_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            dswa_pkg::CSR_FIRST_LOW:   def_ff[0]  <= csr_wdata;
            dswa_pkg::CSR_FIRST_HIGH:  def_ff[1]  <= csr_wdata;
            dswa_pkg::CSR_SECOND_LOW:  def_ff[2]  <= csr_wdata;
            dswa_pkg::CSR_SECOND_HIGH: def_ff[3]  <= csr_wdata;
            dswa_pkg::CSR_CONFIRM:     confirm_ff <= csr_wdata[CW-1:0];
            dswa_pkg::CSR_STEP:        step_ff    <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   assign need = (confirm_ff == '0) ? CW'(1) : confirm_ff;

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign is_sample = s1_req_ff.command == dswa_pkg::CMD_SAMPLE;

   dswa_sensor #(.TEMP_BITS(TEMP_BITS)) u_sensor_first (
      .clock       (clock),
      .reset       (reset),
      .sample_en   (advance && is_sample),
      .valid       (s1_req_ff.first_valid),
      .temp        (s1_req_ff.first_temp),
      .low_lim     (lim_now[0]),
      .high_lim    (lim_now[1]),
      .need        (need),
      .alarm_now   (a1_now),
      .alarm_upd   (a1_upd),
      .lowest_upd  (lo1),
      .highest_upd (hi1)
   );

   dswa_sensor #(.TEMP_BITS(TEMP_BITS)) u_sensor_second (
      .clock       (clock),
      .reset       (reset),
      .sample_en   (advance && is_sample),
      .valid       (s1_req_ff.second_valid),
      .temp        (s1_req_ff.second_temp),
      .low_lim     (lim_now[2]),
      .high_lim    (lim_now[3]),
      .need        (need),
      .alarm_now   (a2_now),
      .alarm_upd   (a2_upd),
      .lowest_upd  (lo2),
      .highest_upd (hi2)
   );

   always_comb begin
      lim_ctrl.step_en   = s1_req_ff.command == dswa_pkg::CMD_STEP_DOWN ||
                           s1_req_ff.command == dswa_pkg::CMD_STEP_UP;
      lim_ctrl.step_down = s1_req_ff.command == dswa_pkg::CMD_STEP_DOWN;
      lim_ctrl.set_en    = s1_req_ff.command == dswa_pkg::CMD_SET_LIMIT;
      lim_ctrl.set_slot  = s1_req_ff.limit_slot;
      lim_ctrl.load_en   = s1_req_ff.command == dswa_pkg::CMD_DEFAULTS;
      lim_ctrl.slot      = slot_ff;
   end

   dswa_limits #(.TEMP_BITS(TEMP_BITS)) u_limits (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .ctrl      (lim_ctrl),
      .step_size (step_ff),
      .set_value (s1_req_ff.limit_value),
      .defaults  (def_ff),
      .lim_now   (lim_now),
      .lim_upd   (lim_upd)
   );

   // mute, slot pointer and the result word
   always_comb begin
      act_now = a1_now || a2_now;
      act_upd = a1_upd || a2_upd;
      mute_in = mute_ff;
      slot_in = slot_ff;
      if (advance) begin
         unique case (s1_req_ff.command)
            dswa_pkg::CMD_SAMPLE: begin
               if (!act_upd) begin
                  mute_in = 1'b0;
               end
            end
            dswa_pkg::CMD_MUTE: begin
               if (act_now) begin
                  mute_in = !mute_ff;
               end
            end
            dswa_pkg::CMD_NEXT_SLOT: slot_in = slot_ff + 2'd1;
            default: ;
         endcase
      end

      slot_wide = WW'($signed(lim_upd[slot_in]));

      rsp_in.first_alarm    = a1_upd;
      rsp_in.second_alarm   = a2_upd;
      rsp_in.alarm_active   = act_upd;
      rsp_in.muted          = mute_in;
      rsp_in.alarm_drive    = act_upd && !mute_in;
      rsp_in.current_slot   = slot_in;
      rsp_in.slot_value     = slot_wide[TW-1:0];
      rsp_in.first_lowest   = lo1;
      rsp_in.first_highest  = hi1;
      rsp_in.second_lowest  = lo2;
      rsp_in.second_highest = hi2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff <= 1'b0;
         slot_ff <= '0;
      end else begin
         mute_ff <= mute_in;
         slot_ff <= slot_in;
      end
   end

endmodule

`default_nettype wire

// File: src/dswa_sensor.sv
// One sensor channel: min/max tracking, window test and confirm counter.
// Depends on dswa_pkg.
`default_nettype none

module dswa_sensor #(
   parameter int TEMP_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                sample_en,
   input  wire logic                                valid,
   input  wire logic signed [dswa_pkg::TEMP_W-1:0]  temp,
   input  wire logic        [TEMP_BITS-1:0]         low_lim,
   input  wire logic        [TEMP_BITS-1:0]         high_lim,
   input  wire logic        [dswa_pkg::CNT_W-1:0]   need,
   output logic                                     alarm_now,
   output logic                                     alarm_upd,
   output logic signed [dswa_pkg::TEMP_W-1:0]       lowest_upd,
   output logic signed [dswa_pkg::TEMP_W-1:0]       highest_upd
);

   localparam int WW = dswa_pkg::WIDE_W;
   localparam int TW = dswa_pkg::TEMP_W;

   logic                     seen_ff, seen_in;
   logic signed [TW-1:0]     low_ff, low_in;
   logic signed [TW-1:0]     high_ff, high_in;
   logic [dswa_pkg::CNT_W-1:0] count_ff, count_in;

   logic signed [WW-1:0] reading;
   logic signed [TW-1:0] reading16;
   logic                 out_window;

   always_comb begin
      reading    = dswa_pkg::sat_wide(WW'(temp), TEMP_BITS);
      reading16  = reading[TW-1:0];
      out_window = valid &&
                   (reading < $signed(WW'($signed(low_lim))) ||
                    reading > $signed(WW'($signed(high_lim))));

      seen_in  = seen_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      count_in = count_ff;
      if (sample_en) begin
         if (valid) begin
            seen_in = 1'b1;
            if (!seen_ff || reading16 < low_ff) begin
               low_in = reading16;
            end
            if (!seen_ff || reading16 > high_ff) begin
               high_in = reading16;
            end
         end
         if (out_window) begin
            if (count_ff < need) begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            count_in = '0;
         end
      end
   end

   assign alarm_now   = count_ff >= need;
   assign alarm_upd   = count_in >= need;
   assign lowest_upd  = low_in;
   assign highest_upd = high_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         low_ff   <= '0;
         high_ff  <= '0;
         count_ff <= '0;
      end else begin
         seen_ff  <= seen_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: src/dswa_limits.sv
// Limit store: four window limits with step, set, restore and crossed-pair swap.
// Depends on dswa_pkg.
`default_nettype none

module dswa_limits #(
   parameter int TEMP_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   fire,
   input  wire dswa_pkg::lim_ctrl_type                 ctrl,
   input  wire logic [dswa_pkg::CNT_W-1:0]             step_size,
   input  wire logic signed [dswa_pkg::TEMP_W-1:0]     set_value,
   input  wire logic [3:0][dswa_pkg::TEMP_W-1:0]       defaults,
   output logic [3:0][TEMP_BITS-1:0]                   lim_now,
   output logic [3:0][TEMP_BITS-1:0]                   lim_upd
);

   localparam int WW = dswa_pkg::WIDE_W;

   logic [3:0][TEMP_BITS-1:0] lim_ff, lim_in;
   logic [3:0][TEMP_BITS-1:0] def_sat, rst_sat;
   logic [TEMP_BITS-1:0]      tmp;
   logic signed [WW-1:0]      cur, delta, stepped, setv;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         def_sat[i] = TEMP_BITS'(dswa_pkg::sat_wide(WW'($signed(defaults[i])), TEMP_BITS));
         rst_sat[i] = TEMP_BITS'(dswa_pkg::sat_wide(
                         WW'($signed(dswa_pkg::LIMIT_RST[i])), TEMP_BITS));
      end

      cur     = WW'($signed(lim_ff[ctrl.slot]));
      delta   = ctrl.step_down ? -$signed(WW'(step_size)) : $signed(WW'(step_size));
      stepped = dswa_pkg::sat_wide(cur + delta, TEMP_BITS);
      setv    = dswa_pkg::sat_wide(WW'(set_value), TEMP_BITS);

      lim_in = lim_ff;
      tmp    = '0;
      if (fire) begin
         if (ctrl.load_en) begin
            lim_in = def_sat;
         end else if (ctrl.step_en || ctrl.set_en) begin
            for (int i = 0; i < 4; i++) begin
               if (ctrl.step_en && ctrl.slot == 2'(i)) begin
                  lim_in[i] = stepped[TEMP_BITS-1:0];
               end
               if (ctrl.set_en && ctrl.set_slot == 2'(i)) begin
                  lim_in[i] = setv[TEMP_BITS-1:0];
               end
            end
            // low above high: swap the pair
            for (int p = 0; p < 4; p += 2) begin
               if ($signed(lim_in[p]) > $signed(lim_in[p+1])) begin
                  tmp         = lim_in[p];
                  lim_in[p]   = lim_in[p+1];
                  lim_in[p+1] = tmp;
               end
            end
         end
      end
   end

   assign lim_now = lim_ff;
   assign lim_upd = lim_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= rst_sat;
      end else begin
         lim_ff <= lim_in;
      end
   end

endmodule

`default_nettype wire
